// ----- rtl/cps_pkg.sv -----
// Shared types, constants and helpers for the column predicate scan block.
// No dependencies; every other file of the block imports this package.
package cps_pkg;

  // Lane geometry of one word.
  localparam int unsigned LANES      = 8;
  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned MASK_BITS  = 8;
  localparam int unsigned LANE_LIMIT = (LANES < MASK_BITS) ? LANES : MASK_BITS;
  localparam int unsigned COUNT_BITS = 4;

  // Configuration port geometry: four registers at 8-byte spacing.
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned CFG_IDX_LSB   = 3;
  localparam int unsigned CFG_IDX_BITS  = 2;

  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [MASK_BITS-1:0]  mask_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [2:0] {
    CMP_LT = 3'd0,
    CMP_GT = 3'd1,
    CMP_LE = 3'd2,
    CMP_GE = 3'd3,
    CMP_EQ = 3'd4,
    CMP_NE = 3'd5
  } cmp_op_e;

  typedef enum logic [1:0] {
    COMB_SET = 2'd0,
    COMB_AND = 2'd1,
    COMB_OR  = 2'd2
  } comb_op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COMPARE_OP     = 2'd0,
    REG_COMBINE_OP     = 2'd1,
    REG_COMPARE_SOURCE = 2'd2,
    REG_LITERAL_VALUE  = 2'd3
  } cfg_reg_e;

  // What the lanes hand to the merging stage for one word.
  typedef struct packed {
    mask_t  raw;
    mask_t  prior;
    count_t count;
    logic   last;
  } stage_t;

  // Extract the code of one lane; bits that lie above the word read as zero.
  function automatic code_t lane_code(word_t packed_codes, int unsigned lane);
    code_t       code;
    int unsigned idx;
    code = '0;
    for (int unsigned b = 0; b < CODE_BITS; b++) begin
      idx = lane * CODE_BITS + b;
      if (idx < WORD_BITS) begin
        code[b] = packed_codes[idx];
      end
    end
    return code;
  endfunction

endpackage

// ----- rtl/cps_lane.sv -----
// One comparison lane: unsigned compare of a code against its operand.
// Depends on cps_pkg for the code type and the compare operation codes.
module cps_lane (
  input  cps_pkg::code_t   code_a_i,
  input  cps_pkg::code_t   code_b_i,
  input  logic [2:0]       op_i,
  output logic             match_o
);
  import cps_pkg::*;

  // Codes outside the defined operations never match.
  always_comb begin
    case (op_i)
      CMP_LT:  match_o = code_a_i <  code_b_i;
      CMP_GT:  match_o = code_a_i >  code_b_i;
      CMP_LE:  match_o = code_a_i <= code_b_i;
      CMP_GE:  match_o = code_a_i >= code_b_i;
      CMP_EQ:  match_o = code_a_i == code_b_i;
      CMP_NE:  match_o = code_a_i != code_b_i;
      default: match_o = 1'b0;
    endcase
  end

endmodule

// ----- rtl/cps_merge.sv -----
// Merging stage: combines the lane match bits with the prior bit-vector and
// clears lanes past the lane count. Depends on cps_pkg.
module cps_merge (
  input  cps_pkg::stage_t  stage_i,
  input  logic [1:0]       combine_op_i,
  output cps_pkg::mask_t   match_mask_o
);
  import cps_pkg::*;

  count_t count_sat;
  mask_t  valid_lanes;
  mask_t  combined;

  // Saturate the lane count at the number of lanes that exist.
  assign count_sat = (stage_i.count > COUNT_BITS'(LANE_LIMIT)) ?
                     COUNT_BITS'(LANE_LIMIT) : stage_i.count;

  // One valid bit per lane below the count.
  always_comb begin
    valid_lanes = '0;
    for (int unsigned i = 0; i < LANE_LIMIT; i++) begin
      valid_lanes[i] = COUNT_BITS'(i) < count_sat;
    end
  end

  // The spare combine code behaves as set.
  always_comb begin
    case (combine_op_i)
      COMB_AND: combined = stage_i.raw & stage_i.prior;
      COMB_OR:  combined = stage_i.raw | stage_i.prior;
      default:  combined = stage_i.raw;
    endcase
  end

  assign match_mask_o = combined & valid_lanes;

endmodule

// ----- rtl/column_predicate_scan.sv -----
// Column predicate scan top level: configuration registers, compare lanes,
// lane stage register, merging stage and output register.
// Depends on cps_pkg, cps_lane and cps_merge.
//
// Usage: each input word carries LANES packed codes of one column, the codes
// of a second column, the prior bit-vector bits, a lane count and a last flag.
// It is accepted when valid_i is high and stall_o is low. Every lane compares
// its code, unsigned, with the literal register or the other column's code;
// the merging stage sets, ANDs or ORs the result with the prior bits and
// clears lanes at or beyond the lane count. One result word per input word
// appears on match_mask_o and last_out_o, taken when valid_o is high and
// stall_i is low.
// Pipeline: the lane compares are captured into the lane stage at the edge
// that accepts the word, and the merge into the output register when the
// lane stage advances, which raises valid_o; the result is taken while
// stall_i is low. Throughput is one word per cycle while the receiver does
// not stall; all lanes work in the same cycle.
// When the receiver stalls, the result holds; if the lane stage is empty, one
// more word is still taken into it before stall_o rises. Reset clears the
// valid flags of both stages and all configuration registers to zero. The user
// must write configuration over the APB port with the pipeline empty; not enforced.
module column_predicate_scan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input word channel
  input  logic                                valid_i,
  output logic                                stall_o,
  input  cps_pkg::word_t                      column_codes_i,
  input  cps_pkg::word_t                      other_codes_i,
  input  cps_pkg::mask_t                      prior_mask_i,
  input  cps_pkg::count_t                     lane_count_i,
  input  logic                                last_in_i,
  // Result word channel
  output logic                                valid_o,
  input  logic                                stall_i,
  output cps_pkg::mask_t                      match_mask_o,
  output logic                                last_out_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cps_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [cps_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [cps_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import cps_pkg::*;

  logic [2:0]             compare_op_q;
  logic [1:0]             combine_op_q;
  logic                   compare_source_q;
  word_t                  literal_value_q;
  logic                   cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_idx;

  logic                   in_accept;
  logic                   s1_valid_q;
  stage_t                 s1_q;
  stage_t                 s1_d;
  logic                   s1_advance;
  logic                   out_valid_q;
  mask_t                  out_mask_q;
  logic                   out_last_q;
  mask_t                  merged_mask;
  mask_t                  raw_match;
  code_t                  literal_code;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[CFG_IDX_LSB +: CFG_IDX_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_op_q     <= '0;
      combine_op_q     <= '0;
      compare_source_q <= 1'b0;
      literal_value_q  <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_COMPARE_OP:     compare_op_q     <= pwdata[2:0];
        REG_COMBINE_OP:     combine_op_q     <= pwdata[1:0];
        REG_COMPARE_SOURCE: compare_source_q <= pwdata[0];
        REG_LITERAL_VALUE:  literal_value_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_COMPARE_OP:     prdata = {{(CFG_DATA_BITS-3){1'b0}}, compare_op_q};
      REG_COMBINE_OP:     prdata = {{(CFG_DATA_BITS-2){1'b0}}, combine_op_q};
      REG_COMPARE_SOURCE: prdata = {{(CFG_DATA_BITS-1){1'b0}}, compare_source_q};
      REG_LITERAL_VALUE:  prdata = literal_value_q;
      default:            prdata = '0;
    endcase
  end

  // Compare lanes, one per code that fits in the result mask.
  assign literal_code = literal_value_q[CODE_BITS-1:0];

  for (genvar g = 0; g < MASK_BITS; g++) begin : g_lane
    if (g < LANE_LIMIT) begin : g_used
      code_t code_b;
      assign code_b = compare_source_q ? lane_code(other_codes_i, g) : literal_code;
      cps_lane u_lane (
        .code_a_i (lane_code(column_codes_i, g)),
        .code_b_i (code_b),
        .op_i     (compare_op_q),
        .match_o  (raw_match[g])
      );
    end else begin : g_unused
      assign raw_match[g] = 1'b0;
    end
  end

  // Pipeline control: each stage moves when the next one is free or moving.
  assign s1_advance = s1_valid_q && (!out_valid_q || !stall_i);
  assign stall_o    = s1_valid_q && !s1_advance;
  assign in_accept  = valid_i && !stall_o;

  assign s1_d = '{raw: raw_match, prior: prior_mask_i, count: lane_count_i,
                  last: last_in_i};

  // Lane stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  cps_merge u_merge (
    .stage_i      (s1_q),
    .combine_op_i (combine_op_q),
    .match_mask_o (merged_mask)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_mask_q <= merged_mask;
      out_last_q <= s1_q.last;
    end
  end

  assign valid_o      = out_valid_q;
  assign match_mask_o = out_mask_q;
  assign last_out_o   = out_last_q;

  // The input is never stalled while the lane stage is empty.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !stall_o)
    else $error("input stalled with empty lane stage");

  // An accepted word always lands in the lane stage.
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted word lost before lane stage");

  // A held lane stage word keeps its contents while the output is stalled.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && stall_i) |=> (s1_valid_q && $stable(s1_q)))
    else $error("lane stage changed under stall");

  // A word leaving the lane stage always appears at the output.
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> valid_o)
    else $error("merged word lost before output register");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for column_predicate_scan: directed table, then random phases.
// Depends on cps_pkg and the column_predicate_scan RTL; expected masks come from a local predictor.
module tb_top;
  import cps_pkg::*;

  // Operation codes the block must treat as "no match" and "set".
  localparam logic [2:0] CMP_SPARE_LO = 3'd6;
  localparam logic [2:0] CMP_SPARE_HI = 3'd7;
  localparam logic [1:0] COMB_SPARE   = 2'd3;

  localparam int unsigned DIRECTED     = 20;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_WORDS  = 120;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned FLUSH_CYCLES = 6;

  typedef struct packed {
    mask_t mask;
    logic  last;
  } scan_result_t;

  // One row of the directed table: register setting, input word, optional known answer.
  typedef struct {
    logic [2:0] cmp;
    logic [1:0] comb;
    logic       src;
    word_t      lit;
    word_t      col;
    word_t      other;
    mask_t      prior;
    count_t     cnt;
    logic       last;
    logic       known;
    mask_t      known_mask;
  } scan_case_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     valid_i = 1'b0;
  logic                     stall_o;
  word_t                    column_codes_i = '0;
  word_t                    other_codes_i = '0;
  mask_t                    prior_mask_i = '0;
  count_t                   lane_count_i = '0;
  logic                     last_in_i = 1'b0;
  logic                     valid_o;
  logic                     stall_i = 1'b0;
  mask_t                    match_mask_o;
  logic                     last_out_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Local copy of the register file, as the block should hold it.
  logic [2:0] cfg_cmp = '0;
  logic [1:0] cfg_comb = '0;
  logic       cfg_src = 1'b0;
  word_t      cfg_lit = '0;

  scan_result_t expected_results[$];
  int unsigned  errors = 0;
  int unsigned  results_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  mode_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;

  column_predicate_scan uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .column_codes_i (column_codes_i),
    .other_codes_i  (other_codes_i),
    .prior_mask_i   (prior_mask_i),
    .lane_count_i   (lane_count_i),
    .last_in_i      (last_in_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .match_mask_o   (match_mask_o),
    .last_out_o     (last_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Pick a code close to an anchor so that compares land on both sides and on equality.
  function automatic code_t near_code(code_t anchor);
    case ($urandom_range(0, 5))
      0: return anchor;
      1: return anchor + code_t'(1);
      2: return anchor - code_t'(1);
      3: return '0;
      4: return '1;
      default: return code_t'($urandom);
    endcase
  endfunction

  // Predict the match mask of one word under the current register setting.
  function automatic mask_t scan_segment(word_t col, word_t other, mask_t prior, count_t cnt);
    mask_t       hits;
    mask_t       lanes_on;
    mask_t       merged;
    code_t       a;
    code_t       b;
    int unsigned n;
    hits     = '0;
    lanes_on = '0;
    n        = (32'(cnt) > LANE_LIMIT) ? LANE_LIMIT : 32'(cnt);
    for (int unsigned i = 0; i < LANE_LIMIT; i++) begin
      // A shift past the top of the word leaves zero, so high lanes read as zero.
      a = code_t'(col >> (i * CODE_BITS));
      b = cfg_src ? code_t'(other >> (i * CODE_BITS)) : code_t'(cfg_lit);
      case (cfg_cmp)
        CMP_LT: hits[i] = (a < b);
        CMP_GT: hits[i] = (a > b);
        CMP_LE: hits[i] = (a <= b);
        CMP_GE: hits[i] = (a >= b);
        CMP_EQ: hits[i] = (a == b);
        CMP_NE: hits[i] = (a != b);
        default: hits[i] = 1'b0;
      endcase
      if (i < n) begin
        lanes_on[i] = 1'b1;
      end
    end
    case (cfg_comb)
      COMB_AND: merged = hits & prior;
      COMB_OR:  merged = hits | prior;
      default:  merged = hits;
    endcase
    return merged & lanes_on;
  endfunction

  function automatic scan_case_t make_case(logic [2:0] cmp, logic [1:0] comb, logic src,
                                           word_t lit, word_t col, word_t other,
                                           mask_t prior, count_t cnt, logic last,
                                           logic known, mask_t known_mask);
    scan_case_t c;
    c.cmp        = cmp;
    c.comb       = comb;
    c.src        = src;
    c.lit        = lit;
    c.col        = col;
    c.other      = other;
    c.prior      = prior;
    c.cnt        = cnt;
    c.last       = last;
    c.known      = known;
    c.known_mask = known_mask;
    return c;
  endfunction

  // One APB write: setup phase, then access phase until pready, then idle and a read-back check.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] value);
    logic [CFG_DATA_BITS-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx) << CFG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COMPARE_OP:     cfg_cmp = value[2:0];
      REG_COMBINE_OP:     cfg_comb = value[1:0];
      REG_COMPARE_SOURCE: cfg_src = value[0];
      default:            cfg_lit = value;
    endcase
    @(posedge clk_i);
    // The address still points at the register, so it reads back what the block kept.
    case (idx)
      REG_COMPARE_OP:     readback = CFG_DATA_BITS'(cfg_cmp);
      REG_COMBINE_OP:     readback = CFG_DATA_BITS'(cfg_comb);
      REG_COMPARE_SOURCE: readback = CFG_DATA_BITS'(cfg_src);
      default:            readback = cfg_lit;
    endcase
    if (prdata !== readback) begin
      $error("prdata: expected %h, got %h", readback, prdata);
      errors++;
    end
  endtask

  // Write all four registers; unused upper bits carry noise the block must ignore.
  task automatic apply_setting(logic [2:0] cmp, logic [1:0] comb, logic src, word_t lit);
    word_t noise;
    noise = rand_word();
    write_reg(REG_COMPARE_OP, {noise[63:3], cmp});
    write_reg(REG_COMBINE_OP, {noise[63:2], comb});
    write_reg(REG_COMPARE_SOURCE, {noise[63:1], src});
    write_reg(REG_LITERAL_VALUE, lit);
  endtask

  // Offer one word and hold it until taken; record the expected result at acceptance.
  task automatic offer_word(word_t col, word_t other, mask_t prior, count_t cnt, logic last,
                            logic known, mask_t known_mask);
    scan_result_t want;
    valid_i        <= 1'b1;
    column_codes_i <= col;
    other_codes_i  <= other;
    prior_mask_i   <= prior;
    lane_count_i   <= cnt;
    last_in_i      <= last;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    want.mask = known ? known_mask : scan_segment(col, other, prior, cnt);
    want.last = last;
    expected_results.push_back(want);
  endtask

  // Sender pacing: bursts of back-to-back words, then usually a gap with junk on the payload.
  task automatic sender_pause();
    int unsigned gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    if (gap > 0) begin
      valid_i        <= 1'b0;
      column_codes_i <= rand_word();
      other_codes_i  <= rand_word();
      prior_mask_i   <= mask_t'($urandom);
      lane_count_i   <= count_t'($urandom);
      last_in_i      <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every expected word has come out.
  task automatic wait_all_results();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Result side: check each taken word against the oldest expectation, then pick the stall.
  always @(posedge clk_i) begin : result_side
    scan_result_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation pending: match_mask %h last_out %b",
               match_mask_o, last_out_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (match_mask_o !== want.mask) begin
          $error("match_mask: expected %h, got %h", want.mask, match_mask_o);
          errors++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, last_out_o);
          errors++;
        end
        results_seen++;
        // Long hold-offs so that the pipeline fills and stall_o backs up the sender.
        if (results_seen == 100 || results_seen == 500) begin
          hold_left = HOLD_CYCLES;
        end
      end
    end
    if (hold_left > 0) begin
      stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: stall_i <= 1'b0;
        1: stall_i <= ($urandom_range(0, 3) == 0);
        2: stall_i <= ($urandom_range(0, 3) != 0);
        default: stall_i <= ~stall_i;
      endcase
    end
  end

  // Watchdog: too long without any word moving on either channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    scan_case_t  rows[DIRECTED];
    word_t       col;
    word_t       other;
    word_t       lit;
    count_t      cnt;
    logic [2:0]  cmp;
    logic [1:0]  comb;
    logic        src;
    int unsigned pick;

    // Directed table: reset state, lane count extremes, literal truncation, every operation,
    // the unused operation codes, and compares against the second column.
    rows[0]  = make_case(CMP_LT, COMB_SET, 1'b0, '0, '1, rand_word(), 8'hFF, 4'd8, 1'b1,
                         1'b1, 8'h00);
    rows[1]  = make_case(CMP_GE, COMB_SET, 1'b0, '0, rand_word(), rand_word(), 8'h00, 4'd8,
                         1'b0, 1'b1, 8'hFF);
    rows[2]  = make_case(CMP_GE, COMB_SET, 1'b0, '0, rand_word(), rand_word(), 8'hFF, 4'd0,
                         1'b1, 1'b1, 8'h00);
    rows[3]  = make_case(CMP_GE, COMB_SET, 1'b0, '0, rand_word(), rand_word(), 8'h00, 4'd15,
                         1'b0, 1'b1, 8'hFF);
    rows[4]  = make_case(CMP_GE, COMB_SET, 1'b0, '0, rand_word(), rand_word(), 8'h00, 4'd3,
                         1'b0, 1'b1, 8'h07);
    rows[5]  = make_case(CMP_GT, COMB_SET, 1'b0, '1, '1, '0, 8'h00, 4'd8, 1'b1,
                         1'b1, 8'h00);
    rows[6]  = make_case(CMP_LE, COMB_SET, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, '0, '1, 8'h00,
                         4'd8, 1'b0, 1'b1, 8'hFF);
    rows[7]  = make_case(CMP_LE, COMB_SET, 1'b0, 64'hFFFF_FFFF_FFFF_FF00,
                         64'h01FF_0080_7F00_FE00, '0, 8'h00, 4'd8, 1'b1, 1'b0, '0);
    rows[8]  = make_case(CMP_EQ, COMB_SET, 1'b0, 64'h5A, 64'h5B5A_015A_FF5A_005A, '0,
                         8'h00, 4'd8, 1'b0, 1'b0, '0);
    rows[9]  = make_case(CMP_NE, COMB_SET, 1'b0, 64'h5A, 64'h5B5A_015A_FF5A_005A, '0,
                         8'h00, 4'd7, 1'b1, 1'b0, '0);
    rows[10] = make_case(CMP_LT, COMB_AND, 1'b0, 64'h80, '0, '1, 8'h0F, 4'd8, 1'b0,
                         1'b1, 8'h0F);
    rows[11] = make_case(CMP_SPARE_LO, COMB_OR, 1'b0, 64'h80, rand_word(), rand_word(),
                         8'hF0, 4'd8, 1'b1, 1'b1, 8'hF0);
    rows[12] = make_case(CMP_SPARE_HI, COMB_SPARE, 1'b0, 64'h80, rand_word(), rand_word(),
                         8'hFF, 4'd8, 1'b0, 1'b1, 8'h00);
    rows[13] = make_case(CMP_SPARE_LO, COMB_OR, 1'b0, 64'h80, rand_word(), rand_word(),
                         8'hFF, 4'd4, 1'b1, 1'b1, 8'h0F);
    col = rand_word();
    rows[14] = make_case(CMP_EQ, COMB_SET, 1'b1, '1, col, col, 8'h00, 4'd8, 1'b0,
                         1'b1, 8'hFF);
    rows[15] = make_case(CMP_LT, COMB_SET, 1'b1, '1, '0, '1, 8'h00, 4'd8, 1'b1,
                         1'b1, 8'hFF);
    rows[16] = make_case(CMP_GT, COMB_SET, 1'b1, '0, '1, '0, 8'hAA, 4'd5, 1'b0,
                         1'b1, 8'h1F);
    rows[17] = make_case(CMP_LE, COMB_AND, 1'b1, '0, rand_word(), rand_word(),
                         mask_t'($urandom), 4'd8, 1'b1, 1'b0, '0);
    rows[18] = make_case(CMP_GE, COMB_OR, 1'b1, '0, rand_word(), rand_word(),
                         mask_t'($urandom), 4'd6, 1'b0, 1'b0, '0);
    rows[19] = make_case(CMP_NE, COMB_SET, 1'b1, '0, '1, 64'hFF00_FF00_00FF_00FF, 8'h00,
                         4'd9, 1'b1, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reprogram only where the row's setting differs from the current one.
    foreach (rows[i]) begin
      if (rows[i].cmp != cfg_cmp || rows[i].comb != cfg_comb || rows[i].src != cfg_src ||
          rows[i].lit != cfg_lit) begin
        wait_all_results();
        apply_setting(rows[i].cmp, rows[i].comb, rows[i].src, rows[i].lit);
      end
      offer_word(rows[i].col, rows[i].other, rows[i].prior, rows[i].cnt, rows[i].last,
                 rows[i].known, rows[i].known_mask);
      sender_pause();
    end

    // Random phases: two pin the literal at its extremes, one compares columns, the rest random.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_all_results();
      cmp  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(CMP_SPARE_LO, CMP_SPARE_HI))
                                         : 3'($urandom_range(CMP_LT, CMP_NE));
      comb = 2'($urandom_range(COMB_SET, COMB_SPARE));
      src  = 1'($urandom_range(0, 1));
      lit  = rand_word();
      if (phase == 0) begin
        cmp  = CMP_LE;
        comb = COMB_AND;
        src  = 1'b0;
        lit  = '0;
      end else if (phase == 1) begin
        cmp  = CMP_LT;
        comb = COMB_OR;
        src  = 1'b0;
        lit  = '1;
      end else if (phase == 2) begin
        src  = 1'b1;
      end
      apply_setting(cmp, comb, src, lit);

      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        col   = rand_word();
        other = rand_word();
        // Mostly codes near the literal, or near the first column's code, to hit boundaries.
        if ($urandom_range(0, 4) != 0) begin
          for (int unsigned l = 0; l < LANE_LIMIT; l++) begin
            if (l * CODE_BITS + CODE_BITS <= WORD_BITS) begin
              col[l*CODE_BITS +: CODE_BITS]   = near_code(code_t'(cfg_lit));
              other[l*CODE_BITS +: CODE_BITS] = near_code(col[l*CODE_BITS +: CODE_BITS]);
            end
          end
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          cnt = count_t'(LANE_LIMIT);
        end else if (pick < 9) begin
          cnt = count_t'($urandom_range(0, LANE_LIMIT));
        end else begin
          cnt = count_t'($urandom_range(LANE_LIMIT + 1, 15));
        end
        offer_word(col, other, mask_t'($urandom), cnt, 1'($urandom), 1'b0, '0);
        // Midway through one phase the sender waits for the pipeline to run dry.
        if (phase == 3 && n == PHASE_WORDS / 2) begin
          wait_all_results();
        end else begin
          sender_pause();
        end
      end
    end

    wait_all_results();
    repeat (FLUSH_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cps_pkg.sv
rtl/cps_lane.sv
rtl/cps_merge.sv
rtl/column_predicate_scan.sv
tb/tb_top.sv
